@@ sv/ubq_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ubq_pkg
// Shared types and constants for the buffered UART receive/transmit queues.
// -----------------------------------------------------------------------------
package ubq_pkg;

   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 32;
   localparam int FUNC_W   = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TX_PUT = 2'd0,
      FUNC_RX_GET = 2'd1,
      FUNC_EVENT  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] tx_byte;
      logic [BYTE_W-1:0] rx_byte;
      logic              status_rx_ready;
      logic              status_tx_ready;
      logic              status_overrun;
      logic              status_noise;
      logic              status_framing;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              read_valid;
      logic [BYTE_W-1:0] send_byte;
      logic              send_valid;
      logic              tx_irq_enable;
      logic [CNT_W-1:0]  rx_drop_count;
      logic [CNT_W-1:0]  tx_drop_count;
      logic [CNT_W-1:0]  overrun_count;
      logic [CNT_W-1:0]  noise_count;
      logic [CNT_W-1:0]  framing_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_stall;
   } stat_type;

endpackage

@@ sv/ubq_req_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ubq_req_if
// Request channel: valid/ready plus one request item.
// -----------------------------------------------------------------------------
interface ubq_req_if import ubq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [BYTE_W-1:0] tx_byte;
   logic [BYTE_W-1:0] rx_byte;
   logic              status_rx_ready;
   logic              status_tx_ready;
   logic              status_overrun;
   logic              status_noise;
   logic              status_framing;

   modport source (
      output valid, func, tx_byte, rx_byte, status_rx_ready, status_tx_ready,
             status_overrun, status_noise, status_framing,
      input  ready
   );
   modport sink (
      input  valid, func, tx_byte, rx_byte, status_rx_ready, status_tx_ready,
             status_overrun, status_noise, status_framing,
      output ready
   );
endinterface

@@ sv/ubq_rsp_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ubq_rsp_if
// Response channel: valid/ready plus one result item.
// -----------------------------------------------------------------------------
interface ubq_rsp_if import ubq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              read_valid;
   logic [BYTE_W-1:0] send_byte;
   logic              send_valid;
   logic              tx_irq_enable;
   logic [CNT_W-1:0]  rx_drop_count;
   logic [CNT_W-1:0]  tx_drop_count;
   logic [CNT_W-1:0]  overrun_count;
   logic [CNT_W-1:0]  noise_count;
   logic [CNT_W-1:0]  framing_count;

   modport source (
      output valid, read_byte, read_valid, send_byte, send_valid, tx_irq_enable,
             rx_drop_count, tx_drop_count, overrun_count, noise_count,
             framing_count,
      input  ready
   );
   modport sink (
      input  valid, read_byte, read_valid, send_byte, send_valid, tx_irq_enable,
             rx_drop_count, tx_drop_count, overrun_count, noise_count,
             framing_count,
      output ready
   );
endinterface

@@ sv/uart_buffered_rx_tx_queues.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// uart_buffered_rx_tx_queues
// Receive and transmit byte ring queues with drop and error counters.
//
// req_chan carries one command beat: queue a transmit byte, read the oldest
// received byte, or report a UART event (error flags, receive-ready with a
// byte, transmit-ready). rsp_chan returns exactly one result beat per
// command, with the read/send bytes, the transmit irq enable flag and all
// counters as they stand after the command.
// A command is captured in IDLE and committed from EXEC once the output
// register can take its result; the result is valid the cycle after the
// commit. No new command is accepted until the commit, since the registered
// queue memory read must see the read pointers the previous command left
// behind. If rsp_chan stalls, one more command is accepted and then held at
// commit until the output register frees up.
// Reset clears pointers, flag and counters; queue contents are not cleared.
// -----------------------------------------------------------------------------
module uart_buffered_rx_tx_queues import ubq_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   ubq_req_if.sink   req_chan,
   ubq_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   req_type  req;
   rsp_type  rsp;

   assign req.func            = req_chan.func;
   assign req.tx_byte         = req_chan.tx_byte;
   assign req.rx_byte         = req_chan.rx_byte;
   assign req.status_rx_ready = req_chan.status_rx_ready;
   assign req.status_tx_ready = req_chan.status_tx_ready;
   assign req.status_overrun  = req_chan.status_overrun;
   assign req.status_noise    = req_chan.status_noise;
   assign req.status_framing  = req_chan.status_framing;

   ubq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ubq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req       (req),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp       (rsp)
   );

   assign rsp_chan.read_byte     = rsp.read_byte;
   assign rsp_chan.read_valid    = rsp.read_valid;
   assign rsp_chan.send_byte     = rsp.send_byte;
   assign rsp_chan.send_valid    = rsp.send_valid;
   assign rsp_chan.tx_irq_enable = rsp.tx_irq_enable;
   assign rsp_chan.rx_drop_count = rsp.rx_drop_count;
   assign rsp_chan.tx_drop_count = rsp.tx_drop_count;
   assign rsp_chan.overrun_count = rsp.overrun_count;
   assign rsp_chan.noise_count   = rsp.noise_count;
   assign rsp_chan.framing_count = rsp.framing_count;

endmodule

@@ sv/ubq_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ubq_ctrl
// Two-state sequencer: take a request beat, then commit it to the datapath.
// -----------------------------------------------------------------------------
module ubq_ctrl import ubq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   // commit waits until the output register can take the result
   assign cmd.commit  = (state_ff == ST_EXEC) && !stat.out_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!stat.out_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC))
      else $error("capture did not move to EXEC");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && stat.out_stall) |=> (state_ff == ST_EXEC))
      else $error("EXEC left while output stalled");

endmodule

@@ sv/ubq_datapath.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ubq_datapath
// Receive and transmit ring memories, pointers, error counters and the
// registered result.
// -----------------------------------------------------------------------------
module ubq_datapath import ubq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   output stat_type stat,
   input  req_type  req,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
   logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

   req_type           req_ff;
   logic [BYTE_W-1:0] rx_rd_data_ff, tx_rd_data_ff;

   logic [RX_PTR_W-1:0] rx_rd_ptr_ff, rx_rd_ptr_in, rx_wr_ptr_ff, rx_wr_ptr_in;
   logic [TX_PTR_W-1:0] tx_rd_ptr_ff, tx_rd_ptr_in, tx_wr_ptr_ff, tx_wr_ptr_in;
   logic [RX_PTR_W-1:0] rx_rd_nxt, rx_wr_nxt;
   logic [TX_PTR_W-1:0] tx_rd_nxt, tx_wr_nxt;

   logic             tx_enable_ff, tx_enable_in;
   logic [CNT_W-1:0] rx_drop_ff, rx_drop_in, tx_drop_ff, tx_drop_in;
   logic [CNT_W-1:0] ovr_ff, ovr_in, noise_ff, noise_in, frm_ff, frm_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   func_type op;
   logic     rx_full, rx_empty, tx_full, tx_empty;
   logic     rx_we, tx_we;

   assign op = func_type'(req_ff.func);

   assign rx_rd_nxt = (rx_rd_ptr_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0
                      : rx_rd_ptr_ff + RX_PTR_W'(1);
   assign rx_wr_nxt = (rx_wr_ptr_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0
                      : rx_wr_ptr_ff + RX_PTR_W'(1);
   assign tx_rd_nxt = (tx_rd_ptr_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0
                      : tx_rd_ptr_ff + TX_PTR_W'(1);
   assign tx_wr_nxt = (tx_wr_ptr_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0
                      : tx_wr_ptr_ff + TX_PTR_W'(1);

   // one slot always left empty
   assign rx_full  = (rx_wr_nxt == rx_rd_ptr_ff);
   assign tx_full  = (tx_wr_nxt == tx_rd_ptr_ff);
   assign rx_empty = (rx_rd_ptr_ff == rx_wr_ptr_ff);
   assign tx_empty = (tx_rd_ptr_ff == tx_wr_ptr_ff);

   assign rx_we = cmd.commit && (op == FUNC_EVENT) && req_ff.status_rx_ready && !rx_full;
   assign tx_we = cmd.commit && (op == FUNC_TX_PUT) && !tx_full;

   assign stat.out_stall = rsp_valid_ff && !rsp_ready;

   always_comb begin
      rx_rd_ptr_in = rx_rd_ptr_ff;
      rx_wr_ptr_in = rx_wr_ptr_ff;
      tx_rd_ptr_in = tx_rd_ptr_ff;
      tx_wr_ptr_in = tx_wr_ptr_ff;
      tx_enable_in = tx_enable_ff;
      rx_drop_in   = rx_drop_ff;
      tx_drop_in   = tx_drop_ff;
      ovr_in       = ovr_ff;
      noise_in     = noise_ff;
      frm_in       = frm_ff;
      rsp_in       = '0;

      unique case (op)
         FUNC_TX_PUT: begin
            if (tx_full) begin
               tx_drop_in = tx_drop_ff + CNT_W'(1);
            end else begin
               tx_wr_ptr_in = tx_wr_nxt;
               tx_enable_in = 1'b1;
            end
         end
         FUNC_RX_GET: begin
            if (!rx_empty) begin
               rsp_in.read_byte  = rx_rd_data_ff;
               rsp_in.read_valid = 1'b1;
               rx_rd_ptr_in      = rx_rd_nxt;
            end
         end
         FUNC_EVENT: begin
            if (req_ff.status_overrun) ovr_in   = ovr_ff + CNT_W'(1);
            if (req_ff.status_noise)   noise_in = noise_ff + CNT_W'(1);
            if (req_ff.status_framing) frm_in   = frm_ff + CNT_W'(1);
            if (req_ff.status_rx_ready) begin
               if (rx_full) rx_drop_in   = rx_drop_ff + CNT_W'(1);
               else         rx_wr_ptr_in = rx_wr_nxt;
            end
            if (req_ff.status_tx_ready) begin
               if (tx_empty) begin
                  tx_enable_in = 1'b0;
               end else begin
                  rsp_in.send_byte  = tx_rd_data_ff;
                  rsp_in.send_valid = 1'b1;
                  tx_rd_ptr_in      = tx_rd_nxt;
               end
            end
         end
         FUNC_NONE: begin
         end
         default: begin
         end
      endcase

      rsp_in.tx_irq_enable = tx_enable_in;
      rsp_in.rx_drop_count = rx_drop_in;
      rsp_in.tx_drop_count = tx_drop_in;
      rsp_in.overrun_count = ovr_in;
      rsp_in.noise_count   = noise_in;
      rsp_in.framing_count = frm_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // queue memories; read data is registered from the current read pointers,
   // which settle at each commit, before the next command is captured
   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_wr_ptr_ff] <= req_ff.rx_byte;
      rx_rd_data_ff <= rx_mem[rx_rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (tx_we) tx_mem[tx_wr_ptr_ff] <= req_ff.tx_byte;
      tx_rd_data_ff <= tx_mem[tx_rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req;
      if (cmd.commit)  rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_rd_ptr_ff <= '0;
         rx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         tx_wr_ptr_ff <= '0;
         tx_enable_ff <= 1'b0;
         rx_drop_ff   <= '0;
         tx_drop_ff   <= '0;
         ovr_ff       <= '0;
         noise_ff     <= '0;
         frm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rx_rd_ptr_ff <= rx_rd_ptr_in;
            rx_wr_ptr_ff <= rx_wr_ptr_in;
            tx_rd_ptr_ff <= tx_rd_ptr_in;
            tx_wr_ptr_ff <= tx_wr_ptr_in;
            tx_enable_ff <= tx_enable_in;
            rx_drop_ff   <= rx_drop_in;
            tx_drop_ff   <= tx_drop_in;
            ovr_ff       <= ovr_in;
            noise_ff     <= noise_in;
            frm_ff       <= frm_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed beat not presented");

   a_tx_put: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (op == FUNC_TX_PUT)) |=>
         (tx_enable_ff || (tx_drop_ff == $past(tx_drop_ff) + CNT_W'(1))))
      else $error("tx put neither enabled irq nor counted a drop");

   a_empty_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.read_valid) |-> (rsp_ff.read_byte == '0))
      else $error("read byte nonzero without read_valid");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the buffered UART receive/transmit queues.
//
// The bench opens with a short directed list: an empty read, transmit-ready
// with nothing queued, the unused command code, extreme bytes and each error
// flag. It then runs random bursts that fill and drain both rings, so the
// full-queue drop paths are reached. A predictor mirrors both rings, the irq
// enable flag and the counters, and each result beat is checked field by
// field against the oldest prediction. Both sides gap at random, but not in a
// steady stretch. The receiver also holds off once for a long stretch, which
// backs the block up and stalls its input.
// -----------------------------------------------------------------------------
module tb;
   import ubq_pkg::*;

   localparam int RANDOM_CMDS  = 600;
   localparam int GAP_PCT      = 38;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 200;
   localparam int STEADY_FROM  = 300;
   localparam int STEADY_TO    = 420;
   localparam int DRAIN_CYCLES = 8;
   localparam int REQ_W        = $bits(req_type);

   logic clock;
   logic reset;

   ubq_req_if req_chan ();
   ubq_rsp_if rsp_chan ();

   uart_buffered_rx_tx_queues i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Predicted block state
   logic [BYTE_W-1:0]   rx_ring [RX_DEPTH];
   logic [BYTE_W-1:0]   tx_ring [TX_DEPTH];
   logic [RX_PTR_W-1:0] rx_head = '0;
   logic [RX_PTR_W-1:0] rx_tail = '0;
   logic [TX_PTR_W-1:0] tx_head = '0;
   logic [TX_PTR_W-1:0] tx_tail = '0;
   logic                irq_en  = 1'b0;
   logic [CNT_W-1:0]    rx_lost = '0;
   logic [CNT_W-1:0]    tx_lost = '0;
   logic [CNT_W-1:0]    overrun_seen = '0;
   logic [CNT_W-1:0]    noise_seen = '0;
   logic [CNT_W-1:0]    framing_seen = '0;

   req_type cmd_pending [$];
   rsp_type queue_results [$];

   int beats_in       = 0;
   int beats_out      = 0;
   int bytes_read     = 0;
   int bytes_sent     = 0;
   int mismatch_count = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   bit steady;

   assign steady = (beats_in >= STEADY_FROM) && (beats_in < STEADY_TO);

   function automatic logic [RX_PTR_W-1:0] rx_next(input logic [RX_PTR_W-1:0] p);
      return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + RX_PTR_W'(1);
   endfunction

   function automatic logic [TX_PTR_W-1:0] tx_next(input logic [TX_PTR_W-1:0] p);
      return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + TX_PTR_W'(1);
   endfunction

   // Applies one command to the predicted rings and returns its result.
   function automatic rsp_type apply_queue_cmd(input req_type c);
      rsp_type r;
      r = '0;
      case (func_type'(c.func))
         FUNC_TX_PUT: begin
            if (tx_next(tx_tail) == tx_head) begin
               tx_lost = tx_lost + CNT_W'(1);
            end else begin
               tx_ring[tx_tail] = c.tx_byte;
               tx_tail = tx_next(tx_tail);
               irq_en = 1'b1;
            end
         end
         FUNC_RX_GET: begin
            if (rx_head != rx_tail) begin
               r.read_byte  = rx_ring[rx_head];
               r.read_valid = 1'b1;
               rx_head = rx_next(rx_head);
               bytes_read++;
            end
         end
         FUNC_EVENT: begin
            if (c.status_overrun) overrun_seen = overrun_seen + CNT_W'(1);
            if (c.status_noise)   noise_seen   = noise_seen + CNT_W'(1);
            if (c.status_framing) framing_seen = framing_seen + CNT_W'(1);
            if (c.status_rx_ready) begin
               if (rx_next(rx_tail) == rx_head) begin
                  rx_lost = rx_lost + CNT_W'(1);
               end else begin
                  rx_ring[rx_tail] = c.rx_byte;
                  rx_tail = rx_next(rx_tail);
               end
            end
            if (c.status_tx_ready) begin
               if (tx_head == tx_tail) begin
                  irq_en = 1'b0;
               end else begin
                  r.send_byte  = tx_ring[tx_head];
                  r.send_valid = 1'b1;
                  tx_head = tx_next(tx_head);
                  bytes_sent++;
               end
            end
         end
         default: ;
      endcase
      r.tx_irq_enable = irq_en;
      r.rx_drop_count = rx_lost;
      r.tx_drop_count = tx_lost;
      r.overrun_count = overrun_seen;
      r.noise_count   = noise_seen;
      r.framing_count = framing_seen;
      return r;
   endfunction

   task automatic report(input string msg);
      mismatch_count++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                              input logic [CNT_W-1:0] want);
      if (got !== want)
         report($sformatf("beat %0d %s: got %0h, expected %0h", beats_out, name, got, want));
   endtask

   function automatic req_type rand_cmd(input func_type f);
      req_type c;
      c = req_type'(REQ_W'($urandom()));
      c.func = f;
      return c;
   endfunction

   // flags order: rx_ready, tx_ready, overrun, noise, framing
   function automatic req_type fixed_cmd(input func_type f, input logic [7:0] txb,
                                         input logic [7:0] rxb, input logic [4:0] flags);
      return req_type'({f, txb, rxb, flags});
   endfunction

   // Command driver
   always @(posedge clock) begin : cmd_driver
      req_type c;
      bit gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         gap = !steady && ($urandom_range(0, 99) < GAP_PCT);
         if (!gap && cmd_pending.size() != 0) begin
            c = cmd_pending.pop_front();
            req_chan.valid           <= 1'b1;
            req_chan.func            <= c.func;
            req_chan.tx_byte         <= c.tx_byte;
            req_chan.rx_byte         <= c.rx_byte;
            req_chan.status_rx_ready <= c.status_rx_ready;
            req_chan.status_tx_ready <= c.status_tx_ready;
            req_chan.status_overrun  <= c.status_overrun;
            req_chan.status_noise    <= c.status_noise;
            req_chan.status_framing  <= c.status_framing;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off once traffic is under way
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= GAP_PCT);
   end

   // Monitor: predict on each command beat, then check each result beat
   always @(posedge clock) begin : beat_monitor
      req_type c;
      rsp_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            c = {req_chan.func, req_chan.tx_byte, req_chan.rx_byte,
                 req_chan.status_rx_ready, req_chan.status_tx_ready,
                 req_chan.status_overrun, req_chan.status_noise, req_chan.status_framing};
            queue_results.push_back(apply_queue_cmd(c));
            beats_in <= beats_in + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (queue_results.size() == 0) begin
               report($sformatf("result beat %0d with no command outstanding", beats_out));
            end else begin
               want = queue_results.pop_front();
               check_field("read_byte",     CNT_W'(rsp_chan.read_byte),
                           CNT_W'(want.read_byte));
               check_field("read_valid",    CNT_W'(rsp_chan.read_valid),
                           CNT_W'(want.read_valid));
               check_field("send_byte",     CNT_W'(rsp_chan.send_byte),
                           CNT_W'(want.send_byte));
               check_field("send_valid",    CNT_W'(rsp_chan.send_valid),
                           CNT_W'(want.send_valid));
               check_field("tx_irq_enable", CNT_W'(rsp_chan.tx_irq_enable),
                           CNT_W'(want.tx_irq_enable));
               check_field("rx_drop_count", rsp_chan.rx_drop_count, want.rx_drop_count);
               check_field("tx_drop_count", rsp_chan.tx_drop_count, want.tx_drop_count);
               check_field("overrun_count", rsp_chan.overrun_count, want.overrun_count);
               check_field("noise_count",   rsp_chan.noise_count,   want.noise_count);
               check_field("framing_count", rsp_chan.framing_count, want.framing_count);
            end
            beats_out++;
         end
      end
   end

   initial begin : stimulus
      req_type c;
      int counted;
      int n;
      int kind;

      reset = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.func            = FUNC_NONE;
      req_chan.tx_byte         = '0;
      req_chan.rx_byte         = '0;
      req_chan.status_rx_ready = 1'b0;
      req_chan.status_tx_ready = 1'b0;
      req_chan.status_overrun  = 1'b0;
      req_chan.status_noise    = 1'b0;
      req_chan.status_framing  = 1'b0;
      rsp_chan.ready           = 1'b0;

      // Directed opening
      cmd_pending.push_back(fixed_cmd(FUNC_RX_GET, 8'hFF, 8'hFF, 5'b11111)); // empty read
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'hA5, 8'h00, 5'b01000)); // tx ready, nothing queued
      cmd_pending.push_back(fixed_cmd(FUNC_NONE,   8'hFF, 8'hFF, 5'b11111));
      cmd_pending.push_back(fixed_cmd(FUNC_TX_PUT, 8'h00, 8'hFF, 5'b11111));
      cmd_pending.push_back(fixed_cmd(FUNC_TX_PUT, 8'hFF, 8'h00, 5'b00000)); // flag already on
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'hFF, 8'hFF, 5'b11111));
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'h00, 8'h00, 5'b10000));
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'h00, 8'h00, 5'b00100));
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'h00, 8'h00, 5'b00010));
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'h00, 8'h00, 5'b00001));
      cmd_pending.push_back(fixed_cmd(FUNC_RX_GET, 8'hFF, 8'h00, 5'b00000));
      cmd_pending.push_back(fixed_cmd(FUNC_RX_GET, 8'h00, 8'hFF, 5'b00000));
      cmd_pending.push_back(fixed_cmd(FUNC_RX_GET, 8'h00, 8'h00, 5'b00000));
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'h00, 8'h00, 5'b01000));
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'h00, 8'h00, 5'b01000)); // clears flag
      cmd_pending.push_back(fixed_cmd(FUNC_EVENT,  8'h00, 8'h5A, 5'b11000)); // flag stays off
      cmd_pending.push_back(fixed_cmd(FUNC_TX_PUT, 8'h3C, 8'h00, 5'b00000));
      cmd_pending.push_back(fixed_cmd(FUNC_NONE,   8'h00, 8'h00, 5'b00000));
      cmd_pending.push_back(fixed_cmd(FUNC_RX_GET, 8'h00, 8'h00, 5'b00000));

      // Random bursts: long ones run a ring past full or past empty
      counted = 0;
      while (counted < RANDOM_CMDS) begin
         kind = $urandom_range(0, 9);
         n = (kind < 6) ? $urandom_range(1, 80) : $urandom_range(1, 20);
         repeat (n) begin
            case (kind)
               0, 1: c = rand_cmd(FUNC_TX_PUT);
               2, 3: begin
                  c = rand_cmd(FUNC_EVENT);
                  c.status_rx_ready = 1'b1;
                  c.status_tx_ready = ($urandom_range(0, 3) == 0);
               end
               4: c = rand_cmd(FUNC_RX_GET);
               5: begin
                  c = rand_cmd(FUNC_EVENT);
                  c.status_tx_ready = 1'b1;
                  c.status_rx_ready = ($urandom_range(0, 3) == 0);
               end
               default: c = rand_cmd(func_type'($urandom_range(0, 3)));
            endcase
            cmd_pending.push_back(c);
            if (c.func != FUNC_NONE) counted++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (cmd_pending.size() != 0 || req_chan.valid || queue_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d commands, checked %0d result beats: %0d bytes read back, %0d sent.",
               beats_in, beats_out, bytes_read, bytes_sent);
      $display("Drops seen: %0d receive, %0d transmit; error events %0d/%0d/%0d.",
               rx_lost, tx_lost, overrun_seen, noise_seen, framing_seen);
      if (mismatch_count == 0) begin
         $display("** uart_buffered_rx_tx_queues: PASSED **");
      end else begin
         $display("** uart_buffered_rx_tx_queues: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Timeout: %0d commands in, %0d results out", beats_in, beats_out);
      $display("** uart_buffered_rx_tx_queues: FAILED **");
      $finish;
   end

endmodule
